@@ hw/rtl/aavr_pkg.sv @@
// Package: shared types, constants and the CORDIC angle table for the axis-angle rotator.
`timescale 1ns / 1ps
`default_nettype none
package aavr_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int AXIS_WIDTH   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int PHASE_W      = 32;
	localparam int CORDIC_W     = 34;  // Q2.30 with headroom
	localparam int CS_W         = 22;  // cos/sin, Q20 clamped to +-1
	localparam int T_W          = 23;  // 1 - cos
	localparam int PP_W         = 2 * AXIS_WIDTH;
	localparam int FRAW_W       = PP_W + T_W;
	localparam int GRAW_W       = AXIS_WIDTH + CS_W;
	localparam int MAT_W        = 29;
	localparam int PIPE_LAT     = CORDIC_STEPS + 8;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic signed [CS_W-1:0]     ONE_Q20         = 22'sd1048576;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vec_x;
		logic signed [COORD_WIDTH-1:0] vec_y;
		logic signed [COORD_WIDTH-1:0] vec_z;
		logic signed [COORD_WIDTH-1:0] scale_w;
		logic signed [AXIS_WIDTH-1:0]  axis_x;
		logic signed [AXIS_WIDTH-1:0]  axis_y;
		logic signed [AXIS_WIDTH-1:0]  axis_z;
		logic [ANGLE_WIDTH-1:0]        turn_angle;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rot_x;
		logic signed [COORD_WIDTH-1:0] rot_y;
		logic signed [COORD_WIDTH-1:0] rot_z;
		logic signed [COORD_WIDTH-1:0] out_w;
	} result_t;

	// atan(2^-i) as a 32-bit turn fraction
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input int unsigned idx);
		logic signed [CORDIC_W-1:0] r;
		case (idx)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aavr_cordic.sv @@
// Pipelined CORDIC: one rotation step per stage, yields cos/sin in Q20.
`timescale 1ns / 1ps
`default_nettype none
module aavr_cordic (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	input  wire logic [aavr_pkg::ANGLE_WIDTH-1:0]         angle,
	output logic                                          out_valid,
	output logic signed [aavr_pkg::CS_W-1:0]              cos_q,
	output logic signed [aavr_pkg::CS_W-1:0]              sin_q
);

	localparam int N = aavr_pkg::CORDIC_STEPS;
	localparam int W = aavr_pkg::CORDIC_W;
	localparam int PW = aavr_pkg::PHASE_W;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic signed [W-1:0] z_s [0:N];
	logic                flip_s [0:N];
	logic                valid_s [0:N];

	logic [PW-1:0] phase;
	logic          flip_in;
	logic [PW-1:0] phase_f;

	// quadrant fold: phases in [1/4, 3/4) turn move by half a turn
	always_comb begin
		phase   = {angle, {(PW - aavr_pkg::ANGLE_WIDTH){1'b0}}};
		flip_in = phase[PW-1] ^ phase[PW-2];
		phase_f = {phase[PW-1] ^ flip_in, phase[PW-2:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= aavr_pkg::CORDIC_GAIN_INV;
		y_s[0]    <= '0;
		z_s[0]    <= W'(signed'(phase_f));
		flip_s[0] <= flip_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [W-1:0] dx, dy, nx, ny, nz;
		always_comb begin
			dx = y_s[i] >>> i;
			dy = x_s[i] >>> i;
			if (!z_s[i][W-1]) begin
				nx = x_s[i] - dx;
				ny = y_s[i] + dy;
				nz = z_s[i] - aavr_pkg::atan_turn(i);
			end else begin
				nx = x_s[i] + dx;
				ny = y_s[i] - dy;
				nz = z_s[i] + aavr_pkg::atan_turn(i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1]    <= nx;
			y_s[i+1]    <= ny;
			z_s[i+1]    <= nz;
			flip_s[i+1] <= flip_s[i];
		end
	end

	function automatic logic signed [aavr_pkg::CS_W-1:0] round_clamp(
		input logic signed [W-1:0] v, input logic neg);
		logic signed [W:0] a;
		logic signed [W:0] r;
		a = neg ? -(W+1)'(v) : (W+1)'(v);
		r = (a + (W+1)'(512)) >>> 10;
		if (r > (W+1)'(aavr_pkg::ONE_Q20))
			return aavr_pkg::ONE_Q20;
		else if (r < -(W+1)'(aavr_pkg::ONE_Q20))
			return -aavr_pkg::ONE_Q20;
		return r[aavr_pkg::CS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= round_clamp(x_s[N], flip_s[N]);
		sin_q <= round_clamp(y_s[N], flip_s[N]);
	end

endmodule
`default_nettype wire

@@ hw/rtl/aavr_row.sv @@
// One matrix row times the vector: split products, sums, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module aavr_row (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        in_valid,
	input  wire logic signed [aavr_pkg::COORD_WIDTH-1:0]     vec [3],
	input  wire logic signed [aavr_pkg::MAT_W-1:0]           mat [3],
	output logic                                             out_valid,
	output logic signed [aavr_pkg::COORD_WIDTH-1:0]          value_q
);

	localparam int CW = aavr_pkg::COORD_WIDTH;
	localparam int MW = aavr_pkg::MAT_W;
	localparam int HP = CW - 16 + MW;   // high product
	localparam int LP = 17 + MW;        // low product
	localparam int HS = HP + 2;
	localparam int LS = LP + 2;
	localparam int HW = (HS > LS ? HS : LS) + 1;

	logic signed [HP-1:0] hi_s1 [3];
	logic signed [LP-1:0] lo_s1 [3];
	logic                 valid_s1, valid_s2;
	logic signed [HS-1:0] acc_hi_s2;
	logic signed [LS-1:0] acc_lo_s2;

	logic signed [HW-1:0] h;
	logic signed [HW-1:0] r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			hi_s1[k] <= HP'(signed'(vec[k][CW-1:16])) * HP'(mat[k]);
			lo_s1[k] <= LP'(signed'({1'b0, vec[k][15:0]})) * LP'(mat[k]);
		end
		acc_hi_s2 <= HS'(hi_s1[0]) + HS'(hi_s1[1]) + HS'(hi_s1[2]);
		acc_lo_s2 <= LS'(lo_s1[0]) + LS'(lo_s1[1]) + LS'(lo_s1[2]);
	end

	// round from Q36 to Q16: the low half contributes floor(lo/2^16) plus the half-LSB of 8
	always_comb begin
		h = HW'(acc_hi_s2) + HW'(acc_lo_s2 >>> 16) + HW'(8);
		r = h >>> 4;
	end

	always_ff @(posedge clk) begin
		if (r > $signed(HW'({1'b0, {(CW-1){1'b1}}})))
			value_q <= {1'b0, {(CW-1){1'b1}}};
		else if (r < -$signed(HW'({1'b0, {(CW-1){1'b1}}})) - HW'(1))
			value_q <= {1'b1, {(CW-1){1'b0}}};
		else
			value_q <= r[CW-1:0];
	end

endmodule
`default_nettype wire

@@ hw/rtl/axis_angle_vector_rotate.sv @@
// Top level: axis-angle (Rodrigues) rotation of a Q16.16 vector, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Command channel: drive cmd and pulse start; a transaction is taken at
//   every rising edge with start high and busy low. busy is always low, so a
//   new vector may be issued every cycle.
//   Result channel: done is high for exactly one cycle with result valid;
//   results leave in issue order. The receiver cannot stall, and nothing
//   here needs it to: the pipeline never holds.
//   Depth: 24 register stages (16 CORDIC steps, phase fold and cos/sin
//   rounding, three matrix-build stages, three row-product stages).
//   Throughput: one transaction per cycle.
//   Pipeline: CORDIC gives cos/sin; stage 1 forms axis pair products and
//   1 - cos; stage 2 multiplies by 1 - cos and sin; stage 3 rounds and adds
//   the matrix entries; each row unit splits the 32-bit coordinate into two
//   halves, sums, rounds and saturates.
//   Reset: asynchronous, active low; clears all valid bits so no spurious
//   done follows reset. Payload registers are not reset.
//   rot_* saturate to the signed 32-bit range; out_w copies scale_w.
module axis_angle_vector_rotate (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire aavr_pkg::cmd_t    cmd,
	output logic                   done,
	output aavr_pkg::result_t      result
);

	localparam int CW = aavr_pkg::COORD_WIDTH;
	localparam int AW = aavr_pkg::AXIS_WIDTH;
	localparam int MW = aavr_pkg::MAT_W;
	localparam int DL = aavr_pkg::CORDIC_STEPS + 1;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---- CORDIC and payload delay line ----
	logic                               cs_valid;
	logic signed [aavr_pkg::CS_W-1:0]   cos_c, sin_c;
	aavr_pkg::cmd_t                     pay_q [0:DL];

	aavr_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (cmd.turn_angle),
		.out_valid (cs_valid),
		.cos_q     (cos_c),
		.sin_q     (sin_c)
	);

	always_ff @(posedge clk) begin
		pay_q[0] <= cmd;
		for (int k = 1; k <= DL; k++) pay_q[k] <= pay_q[k-1];
	end

	// lines up with cos/sin leaving the CORDIC
	aavr_pkg::cmd_t pd;
	assign pd = pay_q[DL];

	// ---- stage 1: axis pair products, 1 - cos ----
	// pair order: xx, yy, zz, xy, xz, yz
	logic                              valid_s1;
	logic signed [aavr_pkg::PP_W-1:0]  pp_s1 [6];
	logic signed [aavr_pkg::T_W-1:0]   t_s1;
	logic signed [aavr_pkg::CS_W-1:0]  c_s1, s_s1;
	logic signed [AW-1:0]              ax_s1 [3];
	logic signed [CW-1:0]              vec_s1 [3];
	logic signed [CW-1:0]              w_s1;

	// ---- stage 2: raw Rodrigues terms ----
	logic                                valid_s2;
	logic signed [aavr_pkg::FRAW_W-1:0]  f_s2 [6];
	logic signed [aavr_pkg::GRAW_W-1:0]  g_s2 [3];
	logic signed [aavr_pkg::CS_W-1:0]    c_s2;
	logic signed [CW-1:0]                vec_s2 [3];
	logic signed [CW-1:0]                w_s2;

	// ---- stage 3: matrix ----
	logic                 valid_s3;
	logic signed [MW-1:0] mat_s3 [3][3];
	logic signed [CW-1:0] vec_s3 [3];
	logic signed [CW-1:0] w_s3, w_s4, w_s5, w_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cs_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1[0]  <= pd.axis_x * pd.axis_x;
		pp_s1[1]  <= pd.axis_y * pd.axis_y;
		pp_s1[2]  <= pd.axis_z * pd.axis_z;
		pp_s1[3]  <= pd.axis_x * pd.axis_y;
		pp_s1[4]  <= pd.axis_x * pd.axis_z;
		pp_s1[5]  <= pd.axis_y * pd.axis_z;
		t_s1      <= aavr_pkg::T_W'(aavr_pkg::ONE_Q20) - aavr_pkg::T_W'(cos_c);
		c_s1      <= cos_c;
		s_s1      <= sin_c;
		ax_s1[0]  <= pd.axis_x;
		ax_s1[1]  <= pd.axis_y;
		ax_s1[2]  <= pd.axis_z;
		vec_s1[0] <= pd.vec_x;
		vec_s1[1] <= pd.vec_y;
		vec_s1[2] <= pd.vec_z;
		w_s1      <= pd.scale_w;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++)
			f_s2[k] <= aavr_pkg::FRAW_W'(pp_s1[k]) * aavr_pkg::FRAW_W'(t_s1);
		for (int k = 0; k < 3; k++)
			g_s2[k] <= aavr_pkg::GRAW_W'(ax_s1[k]) * aavr_pkg::GRAW_W'(s_s1);
		c_s2   <= c_s1;
		vec_s2 <= vec_s1;
		w_s2   <= w_s1;
	end

	// round Q48 -> Q20 and Q34 -> Q20, then assemble R = cI + t n n^T + s [n]x
	logic signed [aavr_pkg::FRAW_W-1:0] fr_full [6];
	logic signed [aavr_pkg::GRAW_W-1:0] gr_full [3];
	logic signed [MW-1:0]               fr [6];
	logic signed [MW-1:0]               gr [3];
	logic signed [MW-1:0]               cm;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			fr_full[k] = (f_s2[k] + aavr_pkg::FRAW_W'(1 << 27)) >>> 28;
			fr[k]      = fr_full[k][MW-1:0];
		end
		for (int k = 0; k < 3; k++) begin
			gr_full[k] = (g_s2[k] + aavr_pkg::GRAW_W'(1 << 13)) >>> 14;
			gr[k]      = gr_full[k][MW-1:0];
		end
		cm = MW'(c_s2);
	end

	always_ff @(posedge clk) begin
		mat_s3[0][0] <= cm + fr[0];
		mat_s3[0][1] <= fr[3] - gr[2];
		mat_s3[0][2] <= fr[4] + gr[1];
		mat_s3[1][0] <= fr[3] + gr[2];
		mat_s3[1][1] <= cm + fr[1];
		mat_s3[1][2] <= fr[5] - gr[0];
		mat_s3[2][0] <= fr[4] - gr[1];
		mat_s3[2][1] <= fr[5] + gr[0];
		mat_s3[2][2] <= cm + fr[2];
		vec_s3       <= vec_s2;
		w_s3         <= w_s2;
		w_s4         <= w_s3;
		w_s5         <= w_s4;
		w_s6         <= w_s5;
	end

	// ---- row products ----
	logic                 row_valid [3];
	logic signed [CW-1:0] row_val [3];

	for (genvar r = 0; r < 3; r++) begin : g_row
		aavr_row u_row (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_s3),
			.vec       (vec_s3),
			.mat       (mat_s3[r]),
			.out_valid (row_valid[r]),
			.value_q   (row_val[r])
		);
	end

	assign done         = row_valid[0];
	assign result.rot_x = row_val[0];
	assign result.rot_y = row_val[1];
	assign result.rot_z = row_val[2];
	assign result.out_w = w_s6;

	// ---- assertions ----
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, aavr_pkg::PIPE_LAT))
		else $error("done without a transaction issued at pipeline latency");

	a_w_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.out_w == $past(cmd.scale_w, aavr_pkg::PIPE_LAT))
		else $error("out_w does not match scale_w of its transaction");

	a_cos_sin_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cs_valid |-> (cos_c <= aavr_pkg::ONE_Q20 && cos_c >= -aavr_pkg::ONE_Q20
			&& sin_c <= aavr_pkg::ONE_Q20 && sin_c >= -aavr_pkg::ONE_Q20))
		else $error("cos/sin out of unit range");

	a_rows_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid[0] == row_valid[1] && row_valid[1] == row_valid[2])
		else $error("row units out of step");

endmodule
`default_nettype wire
